// ----- design/ckq_pkg.sv -----
// Shared codes, field widths and controller/datapath interface types for the queue unit.
package ckq_pkg;

  localparam int REQ_W = 2;
  localparam int QSEL_W = 2;
  localparam int XDATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  localparam int IN_TDATA_W = 32;
  localparam int IN_TUSER_W = REQ_W + QSEL_W;
  localparam int OUT_TDATA_W = 72;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
    logic cap_head;
    logic cap_tail;
    logic load_out;
  } ckq_cmd_t;

  typedef struct packed {
    logic rd_head;
    logic rd_tail;
    logic out_free;
  } ckq_sts_t;

endpackage

// ----- design/ckq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ckq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ckq_ctrl.sv -----
// Request sequencer: accept, execute, memory read steps and result hand-off.
module ckq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ckq_pkg::ckq_sts_t sts,
  output ckq_pkg::ckq_cmd_t cmd
);
  import ckq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RDH = 3'd2;
  localparam logic [2:0] S_RDT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = sts.rd_head ? S_RDH : S_OUT;
      end
      S_RDH: begin
        cmd.cap_head = 1'b1;
        state_nxt = sts.rd_tail ? S_RDT : S_OUT;
      end
      S_RDT: begin
        cmd.cap_tail = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

// ----- design/ckq_dp.sv -----
// Queue datapath: pointers, fill counts, shared element memory and result register.
module ckq_dp #(
  parameter int NUM_QUEUES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ckq_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [ckq_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ckq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  ckq_pkg::ckq_cmd_t                   cmd,
  output ckq_pkg::ckq_sts_t                   sts
);
  import ckq_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);

  logic [PW-1:0]         head_ptr_r [NUM_QUEUES];
  logic [PW-1:0]         tail_ptr_r [NUM_QUEUES];
  logic [CW-1:0]         fill_r [NUM_QUEUES];

  logic [REQ_W-1:0]      req_r;
  logic [QSEL_W-1:0]     qsel_r;
  logic [DATA_WIDTH-1:0] data_r;

  logic [STATUS_W-1:0]   status_r;
  logic [CW-1:0]         occ_r;
  logic                  empty_r;
  logic [DATA_WIDTH-1:0] head_r;
  logic [DATA_WIDTH-1:0] tail_r;
  logic [AW-1:0]         tail_addr_r;
  logic                  rd_tail_r;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                  q_ok;
  logic [QW-1:0]         q_idx;
  logic [PW-1:0]         hp;
  logic [PW-1:0]         tp;
  logic [PW-1:0]         hp_next;
  logic [PW-1:0]         tp_next;
  logic [PW-1:0]         tp_prev;
  logic [CW-1:0]         cur_fill;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         base;
  logic [AW-1:0]         head_addr;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rear_addr;
  logic                  do_push;
  logic                  do_pop;
  logic                  do_peek;
  logic [STATUS_W-1:0]   status_nxt;
  logic [CW-1:0]         fill_nxt;
  logic                  mem_we;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign q_ok = (32'(qsel_r) < 32'(NUM_QUEUES));
  assign q_idx = QW'(qsel_r);
  assign hp = head_ptr_r[q_idx];
  assign tp = tail_ptr_r[q_idx];
  assign cur_fill = fill_r[q_idx];
  assign hp_next = (hp == PW'(QUEUE_DEPTH - 1)) ? '0 : hp + PW'(1);
  assign tp_next = (tp == PW'(QUEUE_DEPTH - 1)) ? '0 : tp + PW'(1);
  assign tp_prev = (tp == '0) ? PW'(QUEUE_DEPTH - 1) : tp - PW'(1);
  assign is_full = (cur_fill == CW'(QUEUE_DEPTH));
  assign is_empty = (cur_fill == '0);

  assign base = AW'(q_idx) * AW'(QUEUE_DEPTH);
  assign head_addr = base + AW'(hp);
  assign wr_addr = base + AW'(tp);
  assign rear_addr = base + AW'(tp_prev);

  assign do_push = q_ok && (req_r == REQ_PUSH) && !is_full;
  assign do_pop = q_ok && (req_r == REQ_POP) && !is_empty;
  assign do_peek = q_ok && (req_r == REQ_PEEK) && !is_empty;

  always_comb begin
    status_nxt = ST_OK;
    fill_nxt = cur_fill;
    if (!q_ok) begin
      status_nxt = ST_EMPTY;
      fill_nxt = '0;
    end else begin
      unique case (req_r)
        REQ_PUSH: begin
          if (is_full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            fill_nxt = cur_fill + CW'(1);
          end
        end
        REQ_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            fill_nxt = cur_fill - CW'(1);
          end
        end
        REQ_PEEK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  assign mem_we = cmd.exec && do_push;
  assign mem_raddr = cmd.exec ? head_addr : tail_addr_r;

  ckq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (data_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_ptr_r[i] <= '0;
        tail_ptr_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_push) begin
        tail_ptr_r[q_idx] <= tp_next;
        fill_r[q_idx] <= fill_nxt;
      end
      if (do_pop) begin
        head_ptr_r[q_idx] <= hp_next;
        fill_r[q_idx] <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_tuser[REQ_W-1:0];
      qsel_r <= in_tuser[REQ_W +: QSEL_W];
      data_r <= DATA_WIDTH'(in_tdata);
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      occ_r <= fill_nxt;
      empty_r <= (fill_nxt == '0);
      head_r <= '0;
      tail_r <= '0;
      tail_addr_r <= rear_addr;
      rd_tail_r <= do_peek;
    end
    if (cmd.cap_head) begin
      head_r <= mem_rdata;
    end
    if (cmd.cap_tail) begin
      tail_r <= mem_rdata;
    end
    if (cmd.load_out) begin
      out_data_r <= {empty_r, OCC_W'(occ_r), XDATA_W'(tail_r), XDATA_W'(head_r), status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.rd_head = do_pop || do_peek;
  assign sts.rd_tail = rd_tail_r;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

// ----- design/k_circular_queues_shared_memory_unit.sv -----
// Top level of the multi-queue unit: several circular queues in one shared memory.
//
//   Channel   Direction  Ports                     Contents (lowest bit first)
//   in_       slave      tvalid tready tdata tuser  tdata: push_data; tuser: req_type, queue_index
//   out_      master     tvalid tready tdata        status, head_value, tail_value, occupancy,
//                                                   queue_empty
//
// A push goes from acceptance through the execute step straight to the result register; a pop
// adds a read of the head element and a peek reads the head and then the tail; a request that
// fails or is ignored follows the push path. The reads of the shared memory are registered,
// one address per cycle.
// Only one request is in flight; in_tready is high while the sequencer is idle.
// A result waits in the output register while out_tready is low; the next word is taken
// meanwhile and held at the hand-off step until the register frees.
// Synchronous active-low reset clears pointers, fill counts and the sequencer; memory is
// not cleared.
module k_circular_queues_shared_memory_unit #(
  parameter int NUM_QUEUES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ckq_pkg::IN_TDATA_W-1:0]  in_tdata,  // push_data
  input  logic [ckq_pkg::IN_TUSER_W-1:0]  in_tuser,  // req_type, queue_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ckq_pkg::OUT_TDATA_W-1:0] out_tdata  // status, head_value, tail_value,
                                                     // occupancy, queue_empty
);
  import ckq_pkg::*;

  ckq_cmd_t cmd;
  ckq_sts_t sts;

  ckq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ckq_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- design/ckq_checker.sv -----
// Port-level checks for the multi-queue unit, bound to the top level.
module ckq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ckq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ckq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result word changed or dropped while stalled.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Second request accepted while one is in flight.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_OK) || (out_tdata[1:0] == ST_OVERFLOW) ||
                   (out_tdata[1:0] == ST_EMPTY))
    else $error("Undefined status code.");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> (out_tdata[65:2] == '0))
    else $error("Failed request returned nonzero element values.");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71] |-> (out_tdata[70:66] == '0))
    else $error("Empty flag set with nonzero occupancy.");

endmodule

bind k_circular_queues_shared_memory_unit ckq_checker u_ckq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/queue_result_checker.sv -----
// Checker that predicts every queue result from the accepted requests and compares it.
module queue_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ckq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ckq_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ckq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            finish_check,
  output int                              fail_count,
  output int                              pending
);
  import ckq_pkg::*;

  localparam int NUM_Q = 4;
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  // Members run from the top bit down, so the word maps straight onto the struct.
  typedef struct packed {
    logic                queue_empty;
    logic [OCC_W-1:0]    occupancy;
    logic [XDATA_W-1:0]  tail_value;
    logic [XDATA_W-1:0]  head_value;
    logic [STATUS_W-1:0] status;
  } queue_result_t;

  logic [XDATA_W-1:0] slot_mem [NUM_Q*DEPTH];
  logic [PTR_W-1:0]   front_ptr [NUM_Q];
  logic [PTR_W-1:0]   rear_ptr [NUM_Q];
  logic [OCC_W-1:0]   fill [NUM_Q];
  queue_result_t      expected_results[$];
  logic               end_checked;

  initial begin
    fail_count = 0;
    pending = 0;
    end_checked = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic queue_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                  input logic [QSEL_W-1:0] qi,
                                                  input logic [XDATA_W-1:0] word);
    queue_result_t r;
    r = '0;
    r.status = ST_OK;
    case (kind)
      REQ_PUSH: begin
        if (fill[qi] == OCC_W'(DEPTH)) begin
          r.status = ST_OVERFLOW;
        end else begin
          slot_mem[{qi, rear_ptr[qi]}] = word;
          rear_ptr[qi] = rear_ptr[qi] + 1'b1;
          fill[qi] = fill[qi] + 1'b1;
        end
      end
      REQ_POP: begin
        if (fill[qi] == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_value = slot_mem[{qi, front_ptr[qi]}];
          front_ptr[qi] = front_ptr[qi] + 1'b1;
          fill[qi] = fill[qi] - 1'b1;
        end
      end
      REQ_PEEK: begin
        if (fill[qi] == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_value = slot_mem[{qi, front_ptr[qi]}];
          r.tail_value = slot_mem[{qi, rear_ptr[qi] - 1'b1}];
        end
      end
      default: begin
      end
    endcase
    r.occupancy = fill[qi];
    r.queue_empty = (fill[qi] == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_Q; i++) begin
        front_ptr[i] = '0;
        rear_ptr[i] = '0;
        fill[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.head_value !== want.head_value)
            report_mismatch($sformatf("head_value %h, expected %h",
                                      got.head_value, want.head_value));
          if (got.tail_value !== want.tail_value)
            report_mismatch($sformatf("tail_value %h, expected %h",
                                      got.tail_value, want.tail_value));
          if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      got.occupancy, want.occupancy));
          if (got.queue_empty !== want.queue_empty)
            report_mismatch($sformatf("queue_empty %b, expected %b",
                                      got.queue_empty, want.queue_empty));
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(in_tuser[REQ_W-1:0],
                                                 in_tuser[REQ_W +: QSEL_W], in_tdata));
      end
      if (finish_check && !end_checked) begin
        end_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives requests into the queue unit and gives the verdict.
module tb;
  import ckq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SKIP = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_ITEMS = 562;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   finish_check;
  int                     fail_count;
  int                     pending;
  int                     send_idle;
  int                     recv_idle;
  int                     quiet_cycles;

  always #1 clk = ~clk;

  k_circular_queues_shared_memory_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  queue_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .finish_check (finish_check),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [QSEL_W-1:0] qi,
                           input logic [XDATA_W-1:0] word);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= {qi, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int sent;
    int mode;
    int len;
    int r;
    logic [QSEL_W-1:0] qi;
    logic [REQ_W-1:0] kind;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(2);
      qi = QSEL_W'($urandom_range(3));
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        case (mode)
          0: kind = (r < 85) ? REQ_PUSH : (r < 95) ? REQ_PEEK : REQ_POP;
          1: kind = (r < 85) ? REQ_POP : (r < 95) ? REQ_PEEK : REQ_PUSH;
          default: begin
            qi = QSEL_W'($urandom_range(3));
            kind = (r < 40) ? REQ_PUSH : (r < 75) ? REQ_POP : (r < 95) ? REQ_PEEK : REQ_SKIP;
          end
        endcase
        send_word(kind, qi, $urandom);
        if (kind != REQ_SKIP) sent++;
      end
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    finish_check = 1'b0;
    quiet_cycles = 0;
    send_idle = 20;
    recv_idle = 61;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(REQ_PEEK, 2'd0, 32'h1234_5678);
    send_word(REQ_POP, 2'd0, 32'hFFFF_FFFF);
    send_word(REQ_PUSH, 2'd0, 32'h8000_0000);
    send_word(REQ_PEEK, 2'd0, 32'h0);
    send_word(REQ_PUSH, 2'd0, 32'h7FFF_FFFF);
    send_word(REQ_PEEK, 2'd0, 32'h0);
    send_word(REQ_POP, 2'd0, 32'h0);
    send_word(REQ_POP, 2'd0, 32'h0);
    send_word(REQ_POP, 2'd0, 32'h0);
    send_word(REQ_SKIP, 2'd2, 32'hFFFF_FFFF);
    send_word(REQ_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_word(REQ_PUSH, 2'd3, 32'h0);
    send_word(REQ_SKIP, 2'd3, 32'h5555_AAAA);
    send_word(REQ_PEEK, 2'd3, 32'h0);
    send_word(REQ_PEEK, 2'd1, 32'h0);

    run_random(PHASE_ITEMS);
    hold_until_drained();
    send_idle = 61;
    recv_idle = 20;
    run_random(PHASE_ITEMS);
    hold_until_drained();
    send_idle = 0;
    recv_idle = 0;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    finish_check <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ckq_pkg.sv
design/ckq_ram.sv
design/ckq_ctrl.sv
design/ckq_dp.sv
design/k_circular_queues_shared_memory_unit.sv
design/ckq_checker.sv
sim/queue_result_checker.sv
sim/tb.sv
